@@ design/tcms_pkg.sv @@
// Shared types and constants of the tower count-min sketch.
package tcms_pkg;

    localparam int unsigned NUM_REGS  = 5;
    localparam int unsigned SEED_W    = 11;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ROW_IDX_W = 3;
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned EST_W     = 32;
    localparam int unsigned MOD_STEPS = 3;

    localparam logic [31:0] MM_MUL    = 32'h5bd1e995;
    localparam logic        CMD_QUERY = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KA,
        ST_KB,
        ST_HC,
        ST_FIN,
        ST_MODI,
        ST_MOD,
        ST_RD,
        ST_UPD,
        ST_DONE
    } state_t;

    // Datapath commands.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_KA,
        OP_KB,
        OP_HC,
        OP_TAIL,
        OP_FIN,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_READ,
        OP_UPDATE,
        OP_CLEAR,
        OP_RESULT
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic blocks_left;
        logic clear_done;
        logic mod_last;
        logic last_row;
        logic is_query;
        logic out_full;
    } dp_status_t;

    // All-ones value of a counter of the given row.
    function automatic logic [31:0] ctr_full(input logic [ROW_IDX_W-1:0] row);
        logic [31:0] full;
        case (row)
            3'd0:    full = 32'hffffffff;
            3'd1:    full = 32'h0000ffff;
            3'd2:    full = 32'h000000ff;
            3'd3:    full = 32'h0000000f;
            3'd4:    full = 32'h00000003;
            default: full = 32'h00000000;
        endcase
        return full;
    endfunction

endpackage

@@ design/tcms_if.sv @@
// Request and result channel interfaces of the tower count-min sketch.
interface tcms_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;

    modport source (output valid, cmd, key_bytes, key_length, input ready);
    modport sink (input valid, cmd, key_bytes, key_length, output ready);
endinterface

interface tcms_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] estimate;

    modport source (output valid, estimate, input ready);
    modport sink (input valid, estimate, output ready);
endinterface

@@ design/tcms_ctrl.sv @@
// Controller state machine of the tower count-min sketch.
module tcms_ctrl
    import tcms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_op_t     op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                op = OP_CLEAR;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_KA;
                end
            end
            ST_KA:
            begin
                // Either start another four-byte block or fold in the tail.
                if (status.blocks_left)
                begin
                    op         = OP_KA;
                    state_next = ST_KB;
                end
                else
                begin
                    op         = OP_TAIL;
                    state_next = ST_FIN;
                end
            end
            ST_KB:
            begin
                op         = OP_KB;
                state_next = ST_HC;
            end
            ST_HC:
            begin
                op         = OP_HC;
                state_next = ST_KA;
            end
            ST_FIN:
            begin
                op         = OP_FIN;
                state_next = ST_MODI;
            end
            ST_MODI:
            begin
                op         = OP_MOD_INIT;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                op = OP_MOD_STEP;
                if (status.mod_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                op         = OP_READ;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                op = OP_UPDATE;
                if (!status.last_row)
                begin
                    state_next = ST_KA;
                end
                else if (status.is_query)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    op         = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ design/tcms_dp.sv @@
// Datapath of the tower count-min sketch: hash, modulo, counter memory, result.
module tcms_dp
    import tcms_pkg::*;
#(
    parameter int unsigned ROWS      = 5,
    parameter int unsigned ROW_WORDS = 1024,
    parameter int unsigned KEY_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_op_t               op,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEED_W-1:0]    cfg_data,
    input  logic                 in_cmd,
    input  logic [KEY_W-1:0]     in_key,
    input  logic [LEN_W-1:0]     in_len,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [EST_W-1:0]     out_estimate,
    output dp_status_t           status
);

    localparam int unsigned DEPTH = ROWS * ROW_WORDS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned MW    = $clog2(ROW_WORDS) + 6;
    localparam int unsigned CW    = $clog2(MOD_STEPS);
    // Scaled reciprocal of the row width; the quotient estimate it gives is
    // at most one below the true quotient.
    localparam logic [31:0] RECIP = 32'(32'hffffffff / ROW_WORDS);

    logic [31:0] mem [DEPTH];

    logic [SEED_W-1:0]    seed_reg [NUM_REGS];
    logic                 cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     pos_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    logic [31:0]          h_reg;
    logic [31:0]          k_reg;
    logic [31:0]          sh_reg;
    logic [31:0]          quo_reg;
    logic [MW-1:0]        rem_reg;
    logic [CW-1:0]        cnt_reg;
    logic [31:0]          rd_reg;
    logic [31:0]          best_reg;
    logic [AW-1:0]        clr_reg;
    logic                 out_valid_reg;
    logic [EST_W-1:0]     est_reg;

    logic [LEN_W-1:0]     len_clamp;
    logic [LEN_W-1:0]     rest;
    logic [31:0]          word_at_pos;
    logic [31:0]          tail;
    logic [31:0]          mul_in;
    logic [31:0]          product;
    logic [31:0]          mod_src;
    logic [63:0]          recip_prod;
    logic [31:0]          part_rem;
    logic [MW-1:0]        rem_fix;
    logic [MW-1:0]        mod_idx;
    logic [ROW_IDX_W-1:0] row_inc;
    logic [SEED_W-1:0]    seed_next_row;
    logic [MW-1:0]        word_idx;
    logic [4:0]           sub_mask;
    logic [4:0]           shift;
    logic [AW-1:0]        addr;
    logic [31:0]          val;
    logic [31:0]          full;

    // Clamp the key length to 1..KEY_BYTES.
    always_comb
    begin
        if (in_len == '0)
        begin
            len_clamp = LEN_W'(1);
        end
        else if (in_len > LEN_W'(KEY_BYTES))
        begin
            len_clamp = LEN_W'(KEY_BYTES);
        end
        else
        begin
            len_clamp = in_len;
        end
    end

    assign rest        = len_reg - pos_reg;
    assign word_at_pos = 32'(key_reg >> {pos_reg, 3'b000});

    always_comb
    begin
        case (rest)
            4'd1:    tail = word_at_pos & 32'h000000ff;
            4'd2:    tail = word_at_pos & 32'h0000ffff;
            4'd3:    tail = word_at_pos & 32'h00ffffff;
            default: tail = 32'h0;
        endcase
    end

    // One constant multiplier shared by all hash steps.
    always_comb
    begin
        case (op)
            OP_KA:   mul_in = word_at_pos;
            OP_KB:   mul_in = k_reg ^ (k_reg >> 24);
            OP_TAIL: mul_in = h_reg ^ tail;
            OP_FIN:  mul_in = h_reg ^ (h_reg >> 13);
            default: mul_in = h_reg;
        endcase
    end

    assign product = mul_in * MM_MUL;

    // The hash modulo ROW_WORDS<<row keeps the low row bits and reduces the
    // rest modulo ROW_WORDS: estimate the quotient by the reciprocal, take the
    // partial remainder, then subtract ROW_WORDS once more if needed.
    assign mod_src    = sh_reg >> row_reg;
    assign recip_prod = 64'(mod_src) * 64'(RECIP);
    assign part_rem   = mod_src - quo_reg * 32'(ROW_WORDS);
    assign rem_fix    = (rem_reg >= MW'(ROW_WORDS)) ? rem_reg - MW'(ROW_WORDS) : rem_reg;
    assign mod_idx    = (rem_fix << row_reg) | MW'(sh_reg[3:0] & sub_mask[3:0]);

    assign row_inc       = row_reg + ROW_IDX_W'(1);
    assign seed_next_row = (row_inc < ROW_IDX_W'(NUM_REGS)) ? seed_reg[row_inc] : '0;

    // Counter selection within the row.
    assign word_idx = rem_reg >> row_reg;
    assign sub_mask = (5'd1 << row_reg) - 5'd1;
    assign shift    = (rem_reg[4:0] & sub_mask) << (3'd5 - row_reg);
    assign addr     = AW'(32'(row_reg) * ROW_WORDS) + AW'(word_idx);
    assign full     = ctr_full(row_reg);
    assign val      = (rd_reg >> shift) & full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                seed_reg[i] <= '0;
            end
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
            begin
                seed_reg[cfg_index] <= cfg_data;
            end
            if (op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg  <= in_cmd;
                key_reg  <= in_key;
                len_reg  <= len_clamp;
                pos_reg  <= '0;
                row_reg  <= '0;
                h_reg    <= 32'(seed_reg[0]) ^ 32'(len_clamp);
                best_reg <= 32'hffffffff;
            end
            OP_KA:
            begin
                k_reg <= product;
            end
            OP_KB:
            begin
                k_reg <= product;
            end
            OP_HC:
            begin
                h_reg   <= product ^ k_reg;
                pos_reg <= pos_reg + LEN_W'(4);
            end
            OP_TAIL:
            begin
                if (rest != '0)
                begin
                    h_reg <= product;
                end
            end
            OP_FIN:
            begin
                h_reg <= product;
            end
            OP_MOD_INIT:
            begin
                sh_reg  <= h_reg ^ (h_reg >> 15);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_MOD_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    quo_reg <= recip_prod[63:32];
                end
                else if (cnt_reg == CW'(1))
                begin
                    rem_reg <= MW'(part_rem);
                end
                else
                begin
                    rem_reg <= mod_idx;
                end
                cnt_reg <= cnt_reg + CW'(1);
            end
            OP_READ:
            begin
                rd_reg <= mem[addr];
            end
            OP_UPDATE:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    if ((val < full) && (val < best_reg))
                    begin
                        best_reg <= val;
                    end
                end
                else if (val < full)
                begin
                    mem[addr] <= rd_reg + (32'd1 << shift);
                end
                row_reg <= row_inc;
                pos_reg <= '0;
                h_reg   <= 32'(seed_next_row) ^ 32'(len_reg);
            end
            OP_CLEAR:
            begin
                mem[clr_reg] <= 32'h0;
            end
            OP_RESULT:
            begin
                est_reg <= best_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.blocks_left = (rest >= LEN_W'(4));
    assign status.clear_done  = (clr_reg == AW'(DEPTH - 1));
    assign status.mod_last    = (cnt_reg == CW'(MOD_STEPS - 1));
    assign status.last_row    = (row_reg == ROW_IDX_W'(ROWS - 1));
    assign status.is_query    = (cmd_reg == CMD_QUERY);
    assign status.out_full    = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign out_estimate = est_reg;

endmodule

@@ design/tower_count_min_sketch.sv @@
// Top level of the tower count-min sketch: controller, datapath and ports.
// Each row runs the multiply, mix and combine steps for every full four-byte key block, then
// tail, finish, modulo setup, three reciprocal modulo steps, read and update; after the last
// row a query passes its estimate to the result register.
// One request is in work at a time and the next is taken only once it has finished; a query
// also waits while an earlier estimate is still unread. Reset clears the counters before the
// first request; seeds reset to zero and may be written meanwhile.
module tower_count_min_sketch
    import tcms_pkg::*;
#(
    parameter int unsigned ROWS      = 5,
    parameter int unsigned ROW_WORDS = 1024,
    parameter int unsigned KEY_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEED_W-1:0]    cfg_data,
    tcms_req_if.sink             req,
    tcms_rsp_if.source           rsp
);

    dp_op_t     op;
    dp_status_t status;
    logic       in_ready;

    // The controller sequences the hash, modulo and memory steps row by row.
    tcms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .status   (status),
        .in_ready (in_ready),
        .op       (op)
    );

    assign req.ready = in_ready;

    // The datapath holds the seeds, the hash state, the counter memory and the
    // result register, which lets a finished estimate wait for the consumer
    // while the next request is already being taken.
    tcms_dp #(
        .ROWS      (ROWS),
        .ROW_WORDS (ROW_WORDS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_cmd       (req.cmd),
        .in_key       (req.key_bytes),
        .in_len       (req.key_length),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_estimate (rsp.estimate),
        .status       (status)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the tower count-min sketch.
`timescale 1ns / 1ps

module tb
    import tcms_pkg::*;
();

    // Holds a private copy of the counter store and the seeds, predicts the
    // estimate of every accepted query and checks the returned estimates.
    class sketch_scoreboard;
        bit [31:0] counter_mem [5120];
        bit [31:0] seeds [NUM_REGS];
        bit [31:0] estimate_queue [$];
        bit        failed;

        function new();
            foreach (counter_mem[i]) counter_mem[i] = '0;
            foreach (seeds[i]) seeds[i] = '0;
            failed = 1'b0;
        endfunction

        function void set_seed(int unsigned index, bit [SEED_W-1:0] value);
            if (index < NUM_REGS) seeds[index] = value;
        endfunction

        function bit [31:0] murmur(bit [63:0] key, int unsigned len, bit [31:0] seed);
            bit [31:0]   h;
            bit [31:0]   k;
            int unsigned pos;
            int unsigned rest;
            h = seed ^ len;
            pos = 0;
            while (len - pos >= 4) begin
                k = key[pos*8 +: 32];
                k = k * MM_MUL;
                k = k ^ (k >> 24);
                k = k * MM_MUL;
                h = h * MM_MUL;
                h = h ^ k;
                pos += 4;
            end
            rest = len - pos;
            if (rest >= 3) h = h ^ ({24'b0, key[(pos+2)*8 +: 8]} << 16);
            if (rest >= 2) h = h ^ ({24'b0, key[(pos+1)*8 +: 8]} << 8);
            if (rest >= 1) begin
                h = h ^ {24'b0, key[pos*8 +: 8]};
                h = h * MM_MUL;
            end
            h = h ^ (h >> 13);
            h = h * MM_MUL;
            h = h ^ (h >> 15);
            return h;
        endfunction

        function void note_request(bit cmd, bit [63:0] key, bit [3:0] len_field);
            int unsigned len;
            int unsigned width;
            bit [31:0]   idx;
            bit [31:0]   full;
            bit [31:0]   val;
            bit [31:0]   best;
            int unsigned word;
            int unsigned shift;
            len = len_field;
            if (len < 1) len = 1;
            if (len > 8) len = 8;
            best = 32'hffffffff;
            for (int r = 0; r < 5; r++) begin
                idx = murmur(key, len, seeds[r]) % (32'd1024 << r);
                word = r * 1024 + (idx >> r);
                width = 32 >> r;
                shift = (idx & ((1 << r) - 1)) * width;
                full = (r == 0) ? 32'hffffffff : ((32'd1 << width) - 1);
                val = (counter_mem[word] >> shift) & full;
                if (cmd == CMD_QUERY) begin
                    if (val < full && val < best) best = val;
                end else if (val < full) begin
                    counter_mem[word] = counter_mem[word] + (32'd1 << shift);
                end
            end
            if (cmd == CMD_QUERY) estimate_queue.push_back(best);
        endfunction

        function void check_estimate(bit [31:0] actual);
            bit [31:0] want;
            if (estimate_queue.size() == 0) begin
                $display("%0t: unexpected estimate %0d", $time, actual);
                failed = 1'b1;
                return;
            end
            want = estimate_queue.pop_front();
            if (want !== actual) begin
                $display("%0t: estimate mismatch, expected %0d actual %0d",
                         $time, want, actual);
                failed = 1'b1;
            end
        endfunction
    endclass

    localparam int unsigned STALL_LIMIT = 20000;
    // A request that makes no result may still be in work after the last
    // estimate came back, so wait longer than one request takes.
    localparam int unsigned SETTLE_CYCLES = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SEED_W-1:0]    cfg_data;

    tcms_req_if req ();
    tcms_rsp_if rsp ();

    tower_count_min_sketch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    sketch_scoreboard sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      quiet_cycles;
    bit [63:0]        key_pool [16];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Result side: checks every accepted estimate, throttles ready according
    // to the current stall rate, and watches for a hung block.
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready) sb.check_estimate(rsp.estimate);
        if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Writes all seed registers plus the three unused indexes, one per cycle.
    // The unused indexes must be ignored by the block.
    task automatic program_seeds(input bit [SEED_W-1:0] v0, input bit [SEED_W-1:0] v1,
                                 input bit [SEED_W-1:0] v2, input bit [SEED_W-1:0] v3,
                                 input bit [SEED_W-1:0] v4);
        bit [SEED_W-1:0] vals [8];
        vals = '{v0, v1, v2, v3, v4, SEED_W'($urandom), SEED_W'($urandom),
                 SEED_W'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            sb.set_seed(i, vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Presents one request, with an optional idle gap ahead of it, and
    // returns once the block has taken it.
    task automatic send_request(input bit cmd, input bit [63:0] key, input bit [3:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.cmd        <= cmd;
        req.key_bytes  <= key;
        req.key_length <= len;
        do @(posedge clk); while (!req.ready);
        sb.note_request(cmd, key, len);
    endtask

    // Stops sending until every expected estimate has arrived and the block
    // has had time to finish any insert still in work.
    task automatic drain();
        req.valid <= 1'b0;
        while (sb.estimate_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic bit [3:0] pick_length();
        // Mostly legal lengths, sometimes zero or beyond the key width.
        if ($urandom_range(9) == 0) return ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    initial
    begin
        bit [63:0] key;
        bit [3:0]  len;
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req.valid      = 1'b0;
        req.cmd        = 1'b0;
        req.key_bytes  = '0;
        req.key_length = 4'd1;
        rsp.ready      = 1'b0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Seeds may be written while the block clears its counters.
        program_seeds('0, '0, '0, '0, '0);

        // Directed requests: a query on an empty sketch, key and length
        // extremes, a short length of zero, lengths beyond the key width and
        // junk bytes past the used length that must not change the hash.
        send_request(CMD_QUERY, 64'h0, 4'd1);
        send_request(1'b0, 64'h0, 4'd0);
        send_request(CMD_QUERY, 64'hffff_ffff_ffff_ff00, 4'd1);
        send_request(1'b0, 64'hffff_ffff_ffff_ffff, 4'd8);
        send_request(1'b0, 64'hffff_ffff_ffff_ffff, 4'd15);
        send_request(CMD_QUERY, 64'hffff_ffff_ffff_ffff, 4'd9);
        send_request(1'b0, 64'h1234_5678_9abc_def0, 4'd3);
        send_request(1'b0, 64'haaaa_aaaa_aa9a_def0, 4'd3);
        send_request(CMD_QUERY, 64'h5555_5555_559a_def0, 4'd3);
        send_request(1'b0, 64'h0102_0304_0506_0708, 4'd5);
        send_request(CMD_QUERY, 64'h0102_0304_0506_0708, 4'd5);
        // Repeated inserts of one key saturate the narrow rows; later
        // queries must skip the saturated counters.
        for (int i = 0; i < 6; i++) send_request(1'b0, 64'h00c0_ffee, 4'd4);
        send_request(CMD_QUERY, 64'h00c0_ffee, 4'd4);
        for (int i = 0; i < 12; i++) send_request(1'b0, 64'h00c0_ffee, 4'd4);
        send_request(CMD_QUERY, 64'h00c0_ffee, 4'd4);

        // Random part, one phase per idling mode, with new seeds in each.
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: program_seeds(11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff);
                1: program_seeds(11'd1228, 11'd1229, 11'd1, 11'd2046, 11'd1024);
                default: program_seeds(SEED_W'($urandom), SEED_W'($urandom),
                                       SEED_W'($urandom), SEED_W'($urandom),
                                       SEED_W'($urandom));
            endcase
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 79 : 9) : 0;
            recv_stall_pct = (phase == 2) ? 79 : ((phase == 3) ? 9 : 0);
            for (int n = 0; n < 232; n++) begin
                if (phase == 0 && n == 116) drain();
                // Mostly keys from a small set so counters climb and the
                // narrow rows saturate; the rest are fresh random keys.
                if ($urandom_range(9) < 7) begin
                    key = key_pool[$urandom_range(15)];
                    len = 4'($urandom_range(4, 8));
                end else begin
                    key = {$urandom, $urandom};
                    len = pick_length();
                end
                send_request(1'($urandom_range(99) < 40), key, len);
            end
        end

        req.valid <= 1'b0;
        while (sb.estimate_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (!sb.failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/tcms_pkg.sv
design/tcms_if.sv
design/tcms_ctrl.sv
design/tcms_dp.sv
design/tower_count_min_sketch.sv
tb/tb.sv
